// ===== hdl/mbq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbq_pkg: shared definitions for the multi-endpoint mailbox queue
// Operation and status codes, default sizes and stream packing offsets.
// ----------------------------------------------------------------------------
package mbq_pkg;

    // default sizes
    localparam int NUM_ENDPOINTS_DEF = 16;
    localparam int QUEUE_DEPTH_DEF   = 8;
    localparam int PAYLOAD_WIDTH_DEF = 64;
    localparam int GRANT_BIT_DEF     = 2;

    // fixed field widths
    localparam int OP_W      = 2;
    localparam int EP_FIELD_W = 4;
    localparam int DATA_W    = 64;
    localparam int RIGHTS_W  = 8;
    localparam int OBJECT_W  = 32;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 4;
    localparam int ENABLE_W  = 16;

    // capability slot: valid bit, rights, object
    localparam int CAP_SLOT_W = 1 + RIGHTS_W + OBJECT_W;

    // operation codes
    localparam logic [OP_W-1:0] OP_SEND     = 2'd0;
    localparam logic [OP_W-1:0] OP_SEND_CAP = 2'd1;
    localparam logic [OP_W-1:0] OP_RECV     = 2'd2;
    localparam logic [OP_W-1:0] OP_QUERY    = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ERR   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

    // input tdata packing
    localparam int IN_EP_LSB     = 0;
    localparam int IN_WR_BIT     = IN_EP_LSB + EP_FIELD_W;
    localparam int IN_DATA_LSB   = IN_WR_BIT + 1;
    localparam int IN_CAPP_BIT   = IN_DATA_LSB + DATA_W;
    localparam int IN_RIGHTS_LSB = IN_CAPP_BIT + 1;
    localparam int IN_OBJ_LSB    = IN_RIGHTS_LSB + RIGHTS_W;
    localparam int IN_TBL_BIT    = IN_OBJ_LSB + OBJECT_W;
    localparam int IN_TDATA_W    = ((IN_TBL_BIT + 1 + 7) / 8) * 8;

    // output tdata packing
    localparam int OUT_USED_W  = DATA_W + 1 + RIGHTS_W + OBJECT_W + COUNT_W + 1;
    localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;

endpackage

// ===== hdl/multi_endpoint_mailbox_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_endpoint_mailbox_queue: mailbox with per-endpoint message rings
// Send, capability send, receive and pending query on up to sixteen endpoints.
// ----------------------------------------------------------------------------
// Usage:
// - s_axis carries one request item: tuser is the operation, tdata the
//   endpoint, permission, payload and capability fields.
// - m_axis carries one result item per request: tuser is the status, tdata
//   the received message, capability, pending count and wake flag.
// - i_cfg_we / i_cfg_wdata write the endpoint enable mask; every one bit
//   also empties that endpoint's ring. Write only while no item is in flight.
// - m_axis_tvalid rises in the cycle after acceptance. One item per cycle is
//   sustained while the receiver does not stall: pointers and counts are read
//   and updated in the accepting cycle, and the slot memory read of a receive
//   lands in its registered read port at the same edge as the result register.
// - Reset disables all endpoints and empties all rings at once; slot memory
//   is not cleared since an empty ring never reads it. No clearing pass.
// - When the receiver stalls, the result register holds; a new item is
//   taken in a cycle in which the result register is empty or being drained.
// ----------------------------------------------------------------------------
module multi_endpoint_mailbox_queue #(
    parameter int NUM_ENDPOINTS = mbq_pkg::NUM_ENDPOINTS_DEF,
    parameter int QUEUE_DEPTH   = mbq_pkg::QUEUE_DEPTH_DEF,
    parameter int PAYLOAD_WIDTH = mbq_pkg::PAYLOAD_WIDTH_DEF,
    parameter int GRANT_BIT     = mbq_pkg::GRANT_BIT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // endpoint enable register
    input  logic                              i_cfg_we,
    input  logic [mbq_pkg::ENABLE_W-1:0]      i_cfg_wdata,
    // request stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: endpoint[3:0], write_permitted[4], payload[68:5], cap_present[69],
    //        cap_rights[77:70], cap_object[109:78], cap_table_ok[110], pad[111]
    input  logic [mbq_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // tuser: op[1:0]
    input  logic [mbq_pkg::OP_W-1:0]          s_axis_tuser,
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata: payload_out[63:0], has_cap_out[64], cap_rights_out[72:65],
    //        cap_object_out[104:73], pending_count[108:105], wake_one[109],
    //        pad[111:110]
    output logic [mbq_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // tuser: status[1:0]
    output logic [mbq_pkg::STATUS_W-1:0]      m_axis_tuser
);

    localparam int EP_W   = (NUM_ENDPOINTS > 1) ? $clog2(NUM_ENDPOINTS) : 1;
    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int SLOTS  = NUM_ENDPOINTS * QUEUE_DEPTH;
    localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PAD_W  = mbq_pkg::OUT_TDATA_W - mbq_pkg::OUT_USED_W;

    // field extraction
    logic [mbq_pkg::EP_FIELD_W-1:0] endpoint;
    logic                           write_permitted;
    logic [mbq_pkg::DATA_W-1:0]     payload;
    logic                           cap_present;
    logic [mbq_pkg::RIGHTS_W-1:0]   cap_rights;
    logic [mbq_pkg::OBJECT_W-1:0]   cap_object;
    logic                           cap_table_ok;

    assign endpoint        = s_axis_tdata[mbq_pkg::IN_EP_LSB +: mbq_pkg::EP_FIELD_W];
    assign write_permitted = s_axis_tdata[mbq_pkg::IN_WR_BIT];
    assign payload         = s_axis_tdata[mbq_pkg::IN_DATA_LSB +: mbq_pkg::DATA_W];
    assign cap_present     = s_axis_tdata[mbq_pkg::IN_CAPP_BIT];
    assign cap_rights      = s_axis_tdata[mbq_pkg::IN_RIGHTS_LSB +: mbq_pkg::RIGHTS_W];
    assign cap_object      = s_axis_tdata[mbq_pkg::IN_OBJ_LSB +: mbq_pkg::OBJECT_W];
    assign cap_table_ok    = s_axis_tdata[mbq_pkg::IN_TBL_BIT];

    // per-endpoint ring state
    logic [mbq_pkg::ENABLE_W-1:0] r_enable;
    logic [PTR_W-1:0]             r_rd_ptr [NUM_ENDPOINTS];
    logic [PTR_W-1:0]             r_wr_ptr [NUM_ENDPOINTS];
    logic [CNT_W-1:0]             r_fill   [NUM_ENDPOINTS];

    // result register
    logic                          r_out_valid;
    logic [mbq_pkg::STATUS_W-1:0]  r_status;
    logic [CNT_W-1:0]              r_count;
    logic                          r_wake;
    logic                          r_rx_ok;
    logic                          r_table_ok;

    // next values
    logic [mbq_pkg::STATUS_W-1:0]  n_status;
    logic [CNT_W-1:0]              n_count;
    logic                          n_wake;
    logic                          n_rx_ok;
    logic                          do_write;
    logic                          do_read;

    logic                          accept;
    logic [EP_W-1:0]               ep_idx;
    logic                          ep_ok;
    logic                          send_ok;
    logic [PTR_W-1:0]              cur_rd;
    logic [PTR_W-1:0]              cur_wr;
    logic [CNT_W-1:0]              cur_cnt;
    logic [ADDR_W-1:0]             base_addr;
    logic [ADDR_W-1:0]             waddr;
    logic [ADDR_W-1:0]             raddr;
    logic [mbq_pkg::CAP_SLOT_W-1:0] wcap;
    logic [mbq_pkg::RIGHTS_W-1:0]  grant_mask;
    logic [NUM_ENDPOINTS-1:0]      clr_mask;

    logic [PAYLOAD_WIDTH-1:0]       rd_payload;
    logic [mbq_pkg::CAP_SLOT_W-1:0] rd_cap;
    logic                           has_cap;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !r_out_valid || m_axis_tready;

    // endpoint lookup
    assign ep_idx     = EP_W'(endpoint);
    assign ep_ok      = (32'(endpoint) < NUM_ENDPOINTS) && r_enable[endpoint];
    assign cur_rd     = r_rd_ptr[ep_idx];
    assign cur_wr     = r_wr_ptr[ep_idx];
    assign cur_cnt    = r_fill[ep_idx];
    assign base_addr  = ADDR_W'(ep_idx) * ADDR_W'(QUEUE_DEPTH);
    assign waddr      = base_addr + ADDR_W'(cur_wr);
    assign raddr      = base_addr + ADDR_W'(cur_rd);
    assign grant_mask = mbq_pkg::RIGHTS_W'(1) << GRANT_BIT;
    assign clr_mask   = NUM_ENDPOINTS'(i_cfg_wdata);

    // send permission, including the grant check of a capability send
    assign send_ok = write_permitted &&
                     !((s_axis_tuser == mbq_pkg::OP_SEND_CAP) &&
                       (!cap_present || ((cap_rights & grant_mask) == '0)));

    // capability slot written by a send
    assign wcap = (s_axis_tuser == mbq_pkg::OP_SEND_CAP) ?
                  {cap_object, cap_rights & ~grant_mask, 1'b1} : '0;

    // operation decode
    always_comb begin
        n_status = mbq_pkg::ST_ERR;
        n_count  = '0;
        n_wake   = 1'b0;
        n_rx_ok  = 1'b0;
        do_write = 1'b0;
        do_read  = 1'b0;
        if (ep_ok) begin
            unique case (s_axis_tuser)
                mbq_pkg::OP_SEND, mbq_pkg::OP_SEND_CAP: begin
                    if (send_ok) begin
                        if (32'(cur_cnt) >= QUEUE_DEPTH) begin
                            n_status = mbq_pkg::ST_FULL;
                            n_count  = cur_cnt;
                        end else begin
                            n_status = mbq_pkg::ST_OK;
                            n_count  = cur_cnt + CNT_W'(1);
                            n_wake   = 1'b1;
                            do_write = 1'b1;
                        end
                    end
                end
                mbq_pkg::OP_RECV: begin
                    if (cur_cnt == '0) begin
                        n_status = mbq_pkg::ST_EMPTY;
                        n_count  = cur_cnt;
                    end else begin
                        n_status = mbq_pkg::ST_OK;
                        n_count  = cur_cnt - CNT_W'(1);
                        n_wake   = 1'b1;
                        n_rx_ok  = 1'b1;
                        do_read  = 1'b1;
                    end
                end
                mbq_pkg::OP_QUERY: begin
                    n_status = mbq_pkg::ST_OK;
                    n_count  = cur_cnt;
                end
                default: begin
                    n_status = mbq_pkg::ST_ERR;
                end
            endcase
        end
    end

    // ring pointers and fill counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= '0;
            for (int e = 0; e < NUM_ENDPOINTS; e++) begin
                r_rd_ptr[e] <= '0;
                r_wr_ptr[e] <= '0;
                r_fill[e]   <= '0;
            end
        end else if (i_cfg_we) begin
            r_enable <= i_cfg_wdata;
            for (int e = 0; e < NUM_ENDPOINTS; e++) begin
                if (clr_mask[e]) begin
                    r_rd_ptr[e] <= '0;
                    r_wr_ptr[e] <= '0;
                    r_fill[e]   <= '0;
                end
            end
        end else if (accept) begin
            if (do_write) begin
                r_wr_ptr[ep_idx] <= (32'(cur_wr) == QUEUE_DEPTH - 1) ? '0 :
                                    cur_wr + PTR_W'(1);
                r_fill[ep_idx]   <= n_count;
            end
            if (do_read) begin
                r_rd_ptr[ep_idx] <= (32'(cur_rd) == QUEUE_DEPTH - 1) ? '0 :
                                    cur_rd + PTR_W'(1);
                r_fill[ep_idx]   <= n_count;
            end
        end
    end

    // result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status   <= n_status;
            r_count    <= n_count;
            r_wake     <= n_wake;
            r_rx_ok    <= n_rx_ok;
            r_table_ok <= cap_table_ok;
        end
    end

    // message slots
    mbq_slot_ram #(
        .DEPTH         (SLOTS),
        .ADDR_W        (ADDR_W),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_slots (
        .i_clk      (i_clk),
        .i_we       (accept && do_write && !i_cfg_we),
        .i_waddr    (waddr),
        .i_wpayload (PAYLOAD_WIDTH'(payload)),
        .i_wcap     (wcap),
        .i_re       (accept && do_read),
        .i_raddr    (raddr),
        .o_rpayload (rd_payload),
        .o_rcap     (rd_cap)
    );

    // result packing, fields zero unless a message was received
    assign has_cap = r_rx_ok && rd_cap[0] && r_table_ok;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_status;
    assign m_axis_tdata  = {
        {PAD_W{1'b0}},
        r_wake,
        mbq_pkg::COUNT_W'(r_count),
        has_cap ? rd_cap[mbq_pkg::CAP_SLOT_W-1:1+mbq_pkg::RIGHTS_W] :
                  {mbq_pkg::OBJECT_W{1'b0}},
        has_cap ? rd_cap[mbq_pkg::RIGHTS_W:1] : {mbq_pkg::RIGHTS_W{1'b0}},
        has_cap,
        r_rx_ok ? mbq_pkg::DATA_W'(rd_payload) : {mbq_pkg::DATA_W{1'b0}}
    };

    // a wake pulse only accompanies a successful operation
    a_wake_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_wake |-> r_status == mbq_pkg::ST_OK)
        else $error("wake raised without ok status");

    // an error result reports no pending messages and no data
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_status == mbq_pkg::ST_ERR |-> r_count == '0 && !r_rx_ok)
        else $error("error result carries count or data");

    // reported count never exceeds the ring depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> 32'(r_count) <= QUEUE_DEPTH)
        else $error("pending count above ring depth");

    // every accepted item shows a result in the next cycle
    a_result_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_out_valid)
        else $error("accepted item produced no result");

endmodule

// ===== hdl/mbq_slot_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbq_slot_ram: message slot storage
// One write port and one read port, read data registered. Each entry holds a
// payload word and a capability slot.
// ----------------------------------------------------------------------------
module mbq_slot_ram #(
    parameter int DEPTH         = mbq_pkg::NUM_ENDPOINTS_DEF * mbq_pkg::QUEUE_DEPTH_DEF,
    parameter int ADDR_W        = 7,
    parameter int PAYLOAD_WIDTH = mbq_pkg::PAYLOAD_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_we,
    input  logic [ADDR_W-1:0]               i_waddr,
    input  logic [PAYLOAD_WIDTH-1:0]        i_wpayload,
    input  logic [mbq_pkg::CAP_SLOT_W-1:0]  i_wcap,
    input  logic                            i_re,
    input  logic [ADDR_W-1:0]               i_raddr,
    output logic [PAYLOAD_WIDTH-1:0]        o_rpayload,
    output logic [mbq_pkg::CAP_SLOT_W-1:0]  o_rcap
);

    localparam int ENTRY_W = PAYLOAD_WIDTH + mbq_pkg::CAP_SLOT_W;

    logic [ENTRY_W-1:0] r_mem [DEPTH];
    logic [ENTRY_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= {i_wcap, i_wpayload};
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rpayload = r_rdata[PAYLOAD_WIDTH-1:0];
    assign o_rcap     = r_rdata[ENTRY_W-1:PAYLOAD_WIDTH];

endmodule

// ===== sim/multi_endpoint_mailbox_queue_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_endpoint_mailbox_queue_tb: self-checking bench for the mailbox queue
// Drives request items on s_axis and keeps its own model of every endpoint
// ring, so each item gets an expected result. Every result on m_axis is
// checked field by field against the oldest expected one. Directed items
// cover disabled endpoints, permission and grant errors, full and empty rings
// and capability drop on receive. Random phases follow, under several enable
// masks and sender and receiver idle patterns.
// ----------------------------------------------------------------------------
module multi_endpoint_mailbox_queue_tb;

    localparam int NUM_EP      = mbq_pkg::NUM_ENDPOINTS_DEF;
    localparam int DEPTH       = mbq_pkg::QUEUE_DEPTH_DEF;
    localparam int GRANT       = mbq_pkg::GRANT_BIT_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 30;

    // request tdata, lowest bit at the bottom of the list
    typedef struct packed {
        logic                         pad;
        logic                         table_ok;
        logic [mbq_pkg::OBJECT_W-1:0] object;
        logic [mbq_pkg::RIGHTS_W-1:0] rights;
        logic                         cap_present;
        logic [mbq_pkg::DATA_W-1:0]   payload;
        logic                         write_ok;
        logic [3:0]                   endpoint;
    } t_request_fields;

    typedef struct packed {
        logic [mbq_pkg::OP_W-1:0] op;
        t_request_fields          f;
    } t_request;

    // result tdata, lowest bit at the bottom of the list
    typedef struct packed {
        logic [1:0]                   pad;
        logic                         wake;
        logic [mbq_pkg::COUNT_W-1:0]  count;
        logic [mbq_pkg::OBJECT_W-1:0] object;
        logic [mbq_pkg::RIGHTS_W-1:0] rights;
        logic                         has_cap;
        logic [mbq_pkg::DATA_W-1:0]   payload;
    } t_result_fields;

    typedef struct packed {
        logic [mbq_pkg::STATUS_W-1:0] status;
        t_result_fields               f;
    } t_result;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [mbq_pkg::ENABLE_W-1:0]    i_cfg_wdata;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    // tdata: endpoint, write_permitted, payload, cap_present, cap_rights,
    //        cap_object, cap_table_ok, pad
    logic [mbq_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
    // tuser: op
    logic [mbq_pkg::OP_W-1:0]        s_axis_tuser;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b1;
    // tdata: payload_out, has_cap_out, cap_rights_out, cap_object_out,
    //        pending_count, wake_one, pad
    logic [mbq_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    // tuser: status
    logic [mbq_pkg::STATUS_W-1:0]    m_axis_tuser;

    multi_endpoint_mailbox_queue DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // mailbox model state
    logic [mbq_pkg::ENABLE_W-1:0]  enable_mask;
    logic [mbq_pkg::DATA_W-1:0]    ring_payload [NUM_EP*DEPTH];
    logic                          ring_cap_valid [NUM_EP*DEPTH];
    logic [mbq_pkg::RIGHTS_W-1:0]  ring_cap_rights [NUM_EP*DEPTH];
    logic [mbq_pkg::OBJECT_W-1:0]  ring_cap_object [NUM_EP*DEPTH];
    int                            head_idx [NUM_EP];
    int                            tail_idx [NUM_EP];
    int                            msg_count [NUM_EP];

    t_result pending_results[$];

    int gap_pct;
    int stall_pct;
    int mismatches;
    int requests_sent;
    int results_seen;
    int mask_writes;
    int caps_delivered;
    int status_tally [4];
    int cycle_count = 0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("multi_endpoint_mailbox_queue regression: fail");
            $finish;
        end
    end

    // receiver backpressure
    always @(posedge i_clk) begin
        m_axis_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end

    function automatic void clear_ring(int e);
        head_idx[e]  = 0;
        tail_idx[e]  = 0;
        msg_count[e] = 0;
    endfunction

    // model of one request: updates the rings and returns the result
    function automatic t_result mailbox_predict(t_request r);
        t_result res;
        int      e;
        int      s;
        logic    send_ok;
        res = '0;
        res.status = mbq_pkg::ST_ERR;
        e = int'(r.f.endpoint);
        if (enable_mask[e]) begin
            case (r.op)
                mbq_pkg::OP_SEND, mbq_pkg::OP_SEND_CAP: begin
                    send_ok = r.f.write_ok;
                    if (r.op == mbq_pkg::OP_SEND_CAP &&
                        (!r.f.cap_present || !r.f.rights[GRANT]))
                        send_ok = 1'b0;
                    if (send_ok) begin
                        if (msg_count[e] >= DEPTH) begin
                            res.status = mbq_pkg::ST_FULL;
                        end else begin
                            s = e * DEPTH + tail_idx[e];
                            ring_payload[s]    = r.f.payload;
                            ring_cap_valid[s]  = (r.op == mbq_pkg::OP_SEND_CAP);
                            ring_cap_rights[s] = '0;
                            ring_cap_object[s] = '0;
                            if (r.op == mbq_pkg::OP_SEND_CAP) begin
                                ring_cap_rights[s] = r.f.rights;
                                ring_cap_rights[s][GRANT] = 1'b0;
                                ring_cap_object[s] = r.f.object;
                            end
                            tail_idx[e]  = (tail_idx[e] + 1) % DEPTH;
                            msg_count[e] = msg_count[e] + 1;
                            res.status = mbq_pkg::ST_OK;
                            res.f.wake = 1'b1;
                        end
                        res.f.count = mbq_pkg::COUNT_W'(msg_count[e]);
                    end
                end
                mbq_pkg::OP_RECV: begin
                    if (msg_count[e] == 0) begin
                        res.status = mbq_pkg::ST_EMPTY;
                    end else begin
                        s = e * DEPTH + head_idx[e];
                        res.f.payload = ring_payload[s];
                        if (ring_cap_valid[s] && r.f.table_ok) begin
                            res.f.has_cap = 1'b1;
                            res.f.rights  = ring_cap_rights[s];
                            res.f.object  = ring_cap_object[s];
                        end
                        head_idx[e]  = (head_idx[e] + 1) % DEPTH;
                        msg_count[e] = msg_count[e] - 1;
                        res.status = mbq_pkg::ST_OK;
                        res.f.wake = 1'b1;
                    end
                    res.f.count = mbq_pkg::COUNT_W'(msg_count[e]);
                end
                default: begin
                    res.status  = mbq_pkg::ST_OK;
                    res.f.count = mbq_pkg::COUNT_W'(msg_count[e]);
                end
            endcase
        end
        return res;
    endfunction

    function automatic t_request make_req(logic [mbq_pkg::OP_W-1:0] op, int e, logic wr,
                                          logic [mbq_pkg::DATA_W-1:0] payload,
                                          logic capp,
                                          logic [mbq_pkg::RIGHTS_W-1:0] rights,
                                          logic [mbq_pkg::OBJECT_W-1:0] object,
                                          logic tbl);
        t_request r;
        r = '0;
        r.op            = op;
        r.f.endpoint    = e[3:0];
        r.f.write_ok    = wr;
        r.f.payload     = payload;
        r.f.cap_present = capp;
        r.f.rights      = rights;
        r.f.object      = object;
        r.f.table_ok    = tbl;
        return r;
    endfunction

    // random request: mostly aimed at a few hot endpoints so rings fill up
    function automatic t_request random_request();
        t_request r;
        int       pick;
        int       e;
        r = '0;
        pick = $urandom_range(99);
        if (pick < 30)
            r.op = mbq_pkg::OP_SEND;
        else if (pick < 52)
            r.op = mbq_pkg::OP_SEND_CAP;
        else if (pick < 90)
            r.op = mbq_pkg::OP_RECV;
        else
            r.op = mbq_pkg::OP_QUERY;
        if ($urandom_range(99) < 80)
            e = 5 * $urandom_range(3);
        else
            e = $urandom_range(NUM_EP - 1);
        r.f.endpoint    = e[3:0];
        r.f.write_ok    = ($urandom_range(99) < 92);
        r.f.payload     = {$urandom, $urandom};
        r.f.cap_present = ($urandom_range(99) < 90);
        r.f.rights      = mbq_pkg::RIGHTS_W'($urandom_range(255));
        if ($urandom_range(99) < 80)
            r.f.rights[GRANT] = 1'b1;
        r.f.object      = $urandom;
        r.f.table_ok    = 1'($urandom_range(1));
        return r;
    endfunction

    // one request item on s_axis; tvalid stays high for a following item
    task automatic send_item(t_request r);
        while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= r.f;
        s_axis_tuser  <= r.op;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        pending_results.push_back(mailbox_predict(r));
        requests_sent++;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // enable mask write, only with nothing in flight
    task automatic write_enable_mask(logic [mbq_pkg::ENABLE_W-1:0] mask);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= mask;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        for (int e = 0; e < NUM_EP; e++)
            if (mask[e])
                clear_ring(e);
        enable_mask = mask;
        mask_writes++;
    endtask

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, want, got);
        end
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_result_fields got;
        t_result        want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected result, expected none, actual status %0d",
                             $time, m_axis_tuser);
            end else begin
                want = pending_results.pop_front();
                status_tally[want.status]++;
                if (want.f.has_cap)
                    caps_delivered++;
                check_field("status", 64'(want.status), 64'(m_axis_tuser));
                check_field("payload_out", want.f.payload, got.payload);
                check_field("has_cap_out", 64'(want.f.has_cap), 64'(got.has_cap));
                check_field("cap_rights_out", 64'(want.f.rights), 64'(got.rights));
                check_field("cap_object_out", 64'(want.f.object), 64'(got.object));
                check_field("pending_count", 64'(want.f.count), 64'(got.count));
                check_field("wake_one", 64'(want.f.wake), 64'(got.wake));
            end
        end
    end

    // every op on endpoints left disabled by reset
    task automatic test_disabled_after_reset();
        send_item(make_req(mbq_pkg::OP_SEND, 0, 1'b1, '1, 1'b1, 8'hFF, '1, 1'b1));
        send_item(make_req(mbq_pkg::OP_SEND_CAP, 15, 1'b1, '1, 1'b1, 8'hFF, '1, 1'b1));
        send_item(make_req(mbq_pkg::OP_RECV, 7, 1'b1, '0, 1'b0, 8'h00, '0, 1'b1));
        send_item(make_req(mbq_pkg::OP_QUERY, 15, 1'b0, '0, 1'b0, 8'h00, '0, 1'b0));
    endtask

    // permission, grant and capability handling on one endpoint
    task automatic test_send_receive_rules();
        write_enable_mask(16'hFFFF);
        send_item(make_req(mbq_pkg::OP_SEND, 15, 1'b1, '1, 1'b1, 8'hFF, '1, 1'b1));
        send_item(make_req(mbq_pkg::OP_SEND_CAP, 15, 1'b1, '0, 1'b1, 8'hFF, '1, 1'b1));
        send_item(make_req(mbq_pkg::OP_SEND_CAP, 15, 1'b1, '1, 1'b1, 8'hFB, '1, 1'b1));
        send_item(make_req(mbq_pkg::OP_SEND_CAP, 15, 1'b1, '1, 1'b0, 8'hFF, '1, 1'b1));
        send_item(make_req(mbq_pkg::OP_SEND, 15, 1'b0, '1, 1'b1, 8'hFF, '1, 1'b1));
        send_item(make_req(mbq_pkg::OP_SEND_CAP, 15, 1'b1, 64'h0123_4567_89AB_CDEF,
                           1'b1, 8'h04, 32'h0000_0001, 1'b0));
        send_item(make_req(mbq_pkg::OP_QUERY, 15, 1'b0, '0, 1'b0, 8'h00, '0, 1'b0));
        send_item(make_req(mbq_pkg::OP_RECV, 15, 1'b0, '1, 1'b0, 8'h00, '0, 1'b1));
        send_item(make_req(mbq_pkg::OP_RECV, 15, 1'b0, '0, 1'b0, 8'h00, '0, 1'b1));
        // capability dropped when the receiver table refuses it
        send_item(make_req(mbq_pkg::OP_RECV, 15, 1'b0, '0, 1'b0, 8'h00, '0, 1'b0));
        send_item(make_req(mbq_pkg::OP_RECV, 15, 1'b0, '0, 1'b0, 8'h00, '0, 1'b1));
    endtask

    // fill a ring past its depth, then query it and receive one message
    task automatic test_full_and_empty();
        for (int i = 0; i <= DEPTH; i++)
            send_item(make_req(mbq_pkg::OP_SEND, 0, 1'b1, {$urandom, $urandom},
                               1'b0, 8'h00, '0, 1'b0));
        send_item(make_req(mbq_pkg::OP_QUERY, 0, 1'b0, '0, 1'b0, 8'h00, '0, 1'b0));
        send_item(make_req(mbq_pkg::OP_RECV, 0, 1'b0, '0, 1'b0, 8'h00, '0, 1'b1));
    endtask

    // a one bit empties a ring even when already enabled; zero disables
    task automatic test_enable_mask_writes();
        write_enable_mask(16'hFFFF);
        send_item(make_req(mbq_pkg::OP_RECV, 0, 1'b0, '0, 1'b0, 8'h00, '0, 1'b1));
        send_item(make_req(mbq_pkg::OP_SEND, 3, 1'b1, '1, 1'b0, 8'h00, '0, 1'b0));
        write_enable_mask(16'h0000);
        send_item(make_req(mbq_pkg::OP_QUERY, 3, 1'b0, '0, 1'b0, 8'h00, '0, 1'b0));
        write_enable_mask(16'h7FFF);
        send_item(make_req(mbq_pkg::OP_SEND, 15, 1'b1, '1, 1'b0, 8'h00, '0, 1'b0));
        send_item(make_req(mbq_pkg::OP_QUERY, 3, 1'b0, '0, 1'b0, 8'h00, '0, 1'b0));
    endtask

    // random traffic under one enable mask and idle pattern
    task automatic test_random_traffic(int n, int sender_idle, int receiver_stall,
                                       logic [mbq_pkg::ENABLE_W-1:0] mask);
        write_enable_mask(mask);
        gap_pct   = sender_idle;
        stall_pct = receiver_stall;
        repeat (n) send_item(random_request());
        drain_results();
        gap_pct   = 0;
        stall_pct = 0;
    endtask

    initial begin
        logic [mbq_pkg::ENABLE_W-1:0] mixed_mask;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= mbq_pkg::OP_SEND;
        gap_pct        = 0;
        stall_pct      = 0;
        mismatches     = 0;
        requests_sent  = 0;
        results_seen   = 0;
        mask_writes    = 0;
        caps_delivered = 0;
        status_tally   = '{default: 0};
        enable_mask    = '0;
        for (int e = 0; e < NUM_EP; e++)
            clear_ring(e);

        // reset
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_disabled_after_reset();
        test_send_receive_rules();
        test_full_and_empty();
        test_enable_mask_writes();

        mixed_mask = mbq_pkg::ENABLE_W'($urandom_range(16'hFFFF)) | 16'h0021;
        test_random_traffic(270, 0, 0, 16'hFFFF);
        test_random_traffic(260, 76, 0, 16'h8421);
        test_random_traffic(260, 0, 76, mixed_mask);
        test_random_traffic(260, 31, 31, 16'hFFFF);

        drain_results();
        $display("covered %0d requests under %0d enable masks: %0d ok, %0d error,",
                 requests_sent, mask_writes, status_tally[mbq_pkg::ST_OK],
                 status_tally[mbq_pkg::ST_ERR]);
        $display("%0d full, %0d empty, %0d capabilities delivered; idle none, sender, %s",
                 status_tally[mbq_pkg::ST_FULL], status_tally[mbq_pkg::ST_EMPTY],
                 caps_delivered, "receiver and both");
        if (mismatches == 0) begin
            $display("multi_endpoint_mailbox_queue regression: pass");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("multi_endpoint_mailbox_queue regression: fail");
        end
        $finish;
    end

endmodule
